// ===== sv/nhfp_pkg.sv =====
// ----------------------------------------------------------------------------
// nhfp_pkg
// Shared types and constants for the host frame parser: phase and status
// codes, the frame marker bytes and the result record passed to the top level.
// ----------------------------------------------------------------------------
package nhfp_pkg;

    // Number of four-byte groups searched for the start code
    localparam logic [3:0] SCAN_GROUPS = 4'd10;

    // Marker bytes of the frame format
    localparam logic [7:0] MARK_FF   = 8'hFF;
    localparam logic [7:0] TFI_HOST  = 8'hD5;
    localparam logic [7:0] ERR_TFI   = 8'h7F;
    localparam logic [7:0] ERR_DCS   = 8'h81;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        PH_SCAN    = 4'd0,
        PH_LEN     = 4'd1,
        PH_LCS     = 4'd2,
        PH_EXT_M   = 4'd3,
        PH_EXT_L   = 4'd4,
        PH_EXT_LCS = 4'd5,
        PH_DATA    = 4'd6,
        PH_DCS     = 4'd7,
        PH_POST    = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_CHECKSUM = 3'd2,
        ST_ERRFRAME = 3'd3,
        ST_LINK     = 3'd4
    } t_status;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] data_byte;
        t_status    status;
        logic       post_bad;
    } t_result;

endpackage

// ===== sv/nhfp_core.sv =====
// ----------------------------------------------------------------------------
// nhfp_core
// Frame parsing state and the per-byte decision logic. One byte is consumed
// on each step; the result for that byte is presented combinationally.
// ----------------------------------------------------------------------------
module nhfp_core import nhfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_err,
    output t_result    o_result
);

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_group,  n_group;
    logic [1:0]  r_off,    n_off;
    logic [15:0] r_window, n_window;
    logic [15:0] r_flen,   n_flen;
    logic [15:0] r_left,   n_left;
    logic [7:0]  r_sum,    n_sum;
    logic [15:0] r_lenb,   n_lenb;
    logic [7:0]  r_first,  n_first;

    // Shared decision terms
    logic [3:0] w_group_inc;
    logic       w_scan_found;
    logic       w_scan_over;
    logic       w_lcs_ext;
    logic       w_lcs_bad;
    logic       w_ext_bad;
    logic       w_errframe;
    logic       w_tfi_bad;
    logic       w_dcs_bad;
    logic       w_first;
    logic       w_clear;
    logic [7:0] w_lcs_sum;
    logic [7:0] w_ext_sum;
    logic [7:0] w_dcs_sum;
    t_result    w_res;

    assign w_group_inc  = r_group + 4'd1;
    assign w_scan_found = r_off[1] && (r_window == 16'd0) && (i_byte == MARK_FF);
    assign w_scan_over  = (r_off == 2'd3) && (w_group_inc >= SCAN_GROUPS);
    assign w_lcs_ext    = (r_lenb[7:0] == MARK_FF) && (i_byte == MARK_FF);
    assign w_lcs_sum    = r_lenb[7:0] + i_byte;
    assign w_lcs_bad    = (w_lcs_sum != 8'd0);
    assign w_ext_sum    = r_lenb[15:8] + r_lenb[7:0] + i_byte;
    assign w_ext_bad    = (w_ext_sum != 8'd0);
    assign w_errframe   = (r_flen == 16'd1) && (r_first == ERR_TFI) && (i_byte == ERR_DCS);
    assign w_tfi_bad    = (r_first != TFI_HOST);
    assign w_dcs_sum    = r_sum + i_byte;
    assign w_dcs_bad    = (w_dcs_sum != 8'd0);
    assign w_first      = (r_left == r_flen);

    // Any closing status, or an unused phase code, wipes the state
    assign w_clear = i_step && ((w_res.valid && (w_res.kind == KIND_STATUS)) ||
                                (r_phase > PH_POST));

    // Result for the byte being consumed
    always_comb begin
        w_res           = '0;
        w_res.status    = ST_OK;
        if (i_step) begin
            if (r_phase == PH_POST) begin
                w_res.valid    = 1'b1;
                w_res.kind     = KIND_STATUS;
                w_res.status   = ST_OK;
                w_res.post_bad = i_err || (i_byte != 8'd0);
            end else if (i_err) begin
                w_res.valid  = 1'b1;
                w_res.kind   = KIND_STATUS;
                w_res.status = ST_LINK;
            end else begin
                unique case (r_phase)
                    PH_SCAN: begin
                        if (!w_scan_found && w_scan_over) begin
                            w_res.valid  = 1'b1;
                            w_res.kind   = KIND_STATUS;
                            w_res.status = ST_INVALID;
                        end
                    end
                    PH_LCS: begin
                        if (!w_lcs_ext && (w_lcs_bad || (r_lenb[7:0] == 8'd0))) begin
                            w_res.valid  = 1'b1;
                            w_res.kind   = KIND_STATUS;
                            w_res.status = w_lcs_bad ? ST_CHECKSUM : ST_INVALID;
                        end
                    end
                    PH_EXT_LCS: begin
                        if (w_ext_bad || (r_lenb == 16'd0)) begin
                            w_res.valid  = 1'b1;
                            w_res.kind   = KIND_STATUS;
                            w_res.status = w_ext_bad ? ST_CHECKSUM : ST_INVALID;
                        end
                    end
                    PH_DATA: begin
                        if (!w_first) begin
                            w_res.valid     = 1'b1;
                            w_res.kind      = KIND_DATA;
                            w_res.data_byte = i_byte;
                        end
                    end
                    PH_DCS: begin
                        if (w_errframe) begin
                            w_res.valid  = 1'b1;
                            w_res.kind   = KIND_STATUS;
                            w_res.status = ST_ERRFRAME;
                        end else if (w_tfi_bad || w_dcs_bad) begin
                            w_res.valid  = 1'b1;
                            w_res.kind   = KIND_STATUS;
                            w_res.status = w_tfi_bad ? ST_INVALID : ST_CHECKSUM;
                        end
                    end
                    default: begin
                        w_res.valid = 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_result = w_res;

    // Next phase and datapath state
    always_comb begin
        n_phase  = r_phase;
        n_group  = r_group;
        n_off    = r_off;
        n_window = r_window;
        n_flen   = r_flen;
        n_left   = r_left;
        n_sum    = r_sum;
        n_lenb   = r_lenb;
        n_first  = r_first;
        if (i_step && !i_err) begin
            unique case (r_phase)
                PH_SCAN: begin
                    n_window = {r_window[7:0], i_byte};
                    if (w_scan_found) begin
                        n_window = '0;
                        n_off    = '0;
                        n_group  = '0;
                        n_phase  = PH_LEN;
                    end else if (r_off == 2'd3) begin
                        n_off   = '0;
                        n_group = w_group_inc;
                    end else begin
                        n_off = r_off + 2'd1;
                    end
                end
                PH_LEN: begin
                    n_lenb  = {8'd0, i_byte};
                    n_phase = PH_LCS;
                end
                PH_LCS: begin
                    if (w_lcs_ext) begin
                        n_lenb  = '0;
                        n_phase = PH_EXT_M;
                    end else begin
                        n_flen  = {8'd0, r_lenb[7:0]};
                        n_left  = {8'd0, r_lenb[7:0]};
                        n_sum   = '0;
                        n_phase = PH_DATA;
                    end
                end
                PH_EXT_M: begin
                    n_lenb  = {i_byte, 8'd0};
                    n_phase = PH_EXT_L;
                end
                PH_EXT_L: begin
                    n_lenb  = r_lenb | {8'd0, i_byte};
                    n_phase = PH_EXT_LCS;
                end
                PH_EXT_LCS: begin
                    n_flen  = r_lenb;
                    n_left  = r_lenb;
                    n_sum   = '0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_sum  = r_sum + i_byte;
                    n_left = r_left - 16'd1;
                    if (r_left == 16'd1) begin
                        n_phase = PH_DCS;
                    end
                    if (w_first) begin
                        n_first = i_byte;
                    end
                end
                PH_DCS: begin
                    n_phase = PH_POST;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        // Closing status or bad phase: back to scanning, everything cleared
        if (w_clear) begin
            n_phase  = PH_SCAN;
            n_group  = '0;
            n_off    = '0;
            n_window = '0;
            n_flen   = '0;
            n_left   = '0;
            n_sum    = '0;
            n_lenb   = '0;
            n_first  = '0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SCAN;
            r_group  <= '0;
            r_off    <= '0;
            r_window <= '0;
            r_flen   <= '0;
            r_left   <= '0;
            r_sum    <= '0;
            r_lenb   <= '0;
            r_first  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_group  <= n_group;
            r_off    <= n_off;
            r_window <= n_window;
            r_flen   <= n_flen;
            r_left   <= n_left;
            r_sum    <= n_sum;
            r_lenb   <= n_lenb;
            r_first  <= n_first;
        end
    end

endmodule

// ===== sv/nfc_host_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// nfc_host_frame_parser_unit
// Parses host frames from a byte stream: start code search, length checks,
// payload byte forwarding and a closing status per response.
// ----------------------------------------------------------------------------
// Pipeline: two register stages; an accepted byte is held in the input
// register, then the parse logic writes its result into the result
// register.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or being taken.
// Reset: synchronous, active low; clears all parse state and empties both
// registers, leaving the block scanning for a start code.
module nfc_host_frame_parser_unit import nhfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_link_error,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_kind,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_status_code,
    output logic       o_postamble_bad
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_err;
    logic       r_out_valid;
    logic       r_kind;
    logic [7:0] r_data;
    logic [2:0] r_status;
    logic       r_post_bad;
    logic       w_out_free;
    logic       w_step;
    t_result    w_res;

    // Handshake: the held byte moves on when the result slot can take it
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_rx_byte;
            r_in_err  <= i_link_error;
        end
    end

    nhfp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_err    (r_in_err),
        .o_result (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_kind     <= w_res.kind;
            r_data     <= w_res.data_byte;
            r_status   <= w_res.status;
            r_post_bad <= w_res.post_bad;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_data_byte     = r_data;
    assign o_status_code   = r_status;
    assign o_postamble_bad = r_post_bad;

endmodule
